// ----- sv/res_pkg.sv -----
`default_nettype none

package res_pkg;

  // capacity and field widths
  localparam int MAX_RECORDS = 32;
  localparam int NAME_CHARS  = 8;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int NAME_W      = 64;
  localparam int SCORE_W     = 10;
  localparam int SUM_W       = 12;
  localparam int Q_W         = 10;
  localparam int AVG_W       = 24;
  localparam int FRAC_W      = 14;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 120;

  // only the top NAME_CHARS bytes of a name are kept
  localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} << (8 * (8 - NAME_CHARS));

  // sum / 3 as (sum * 2731) >> 13, exact for every sum below 3072
  localparam int RECIP_W = 12;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = 12'd2731;
  localparam int RECIP_SHIFT = 13;
  localparam logic [AVG_W-1:0] TEN_THOUSAND = 24'd10000;

  // sort key selector codes
  localparam logic [1:0] KEY_KEEP = 2'd0;
  localparam logic [1:0] KEY_AVG  = 2'd1;
  localparam logic [1:0] KEY_NAME = 2'd2;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
    logic [SCORE_W-1:0] score_c;
  } rec_t;

  typedef enum logic {
    WSRC_INPUT = 1'b0,
    WSRC_CUR   = 1'b1
  } wsrc_t;

  typedef struct packed {
    logic             wr_en;
    wsrc_t            wr_src;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             cur_load;
    logic             by_name;
    logic             calc_load;
    logic             out_load;
    logic             out_last;
    logic             out_dropped;
  } res_cmd_t;

  typedef struct packed {
    logic greater;
    logic out_free;
  } res_status_t;

  function automatic logic [SUM_W-1:0] score_sum(input rec_t r);
    score_sum = SUM_W'(r.score_a) + SUM_W'(r.score_b) + SUM_W'(r.score_c);
  endfunction

  // fractional part of (3q + r) * 10000 / 3, rounded to nearest
  function automatic logic [FRAC_W-1:0] third_frac_e4(input logic [1:0] r);
    case (r)
      2'd1:    third_frac_e4 = 14'd3333;
      2'd2:    third_frac_e4 = 14'd6667;
      default: third_frac_e4 = 14'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- sv/res_datapath.sv -----
`default_nettype none

module res_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire res_pkg::res_cmd_t                   cmd,
  output res_pkg::res_status_t                     status,
  input  wire logic [res_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [res_pkg::OUT_DATA_W-1:0]           m_tdata,
  output logic [0:0]                               m_tuser,
  output logic                                     m_tlast
);

  localparam int SUM_W   = res_pkg::SUM_W;
  localparam int AVG_W   = res_pkg::AVG_W;
  localparam int PROD_W  = res_pkg::SUM_W + res_pkg::RECIP_W;

  res_pkg::rec_t rec_mem [res_pkg::MAX_RECORDS];
  res_pkg::rec_t in_rec;
  res_pkg::rec_t wr_rec;
  res_pkg::rec_t rd_rec;
  res_pkg::rec_t cur;
  res_pkg::rec_t calc_rec;
  logic [res_pkg::Q_W-1:0]   calc_q;
  logic [1:0]                calc_r;

  logic [SUM_W-1:0]  rd_sum;
  logic [SUM_W-1:0]  cur_sum;
  logic [PROD_W-1:0] recip_prod;
  logic [res_pkg::Q_W-1:0] q;
  logic [SUM_W-1:0]  r_full;
  logic [AVG_W-1:0]  avg;

  logic [res_pkg::OUT_DATA_W-1:0] out_data;
  logic out_last;
  logic out_dropped;

  // unpack the input transfer
  always_comb begin
    in_rec.name    = s_tdata[63:0] & res_pkg::NAME_MASK;
    in_rec.score_a = s_tdata[73:64];
    in_rec.score_b = s_tdata[83:74];
    in_rec.score_c = s_tdata[93:84];
  end

  assign wr_rec = (cmd.wr_src == res_pkg::WSRC_CUR) ? cur : in_rec;

  // record store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      rec_mem[cmd.wr_addr] <= wr_rec;
    end
    rd_rec <= rec_mem[cmd.rd_addr];
  end

  // running candidate for the current sort position
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur <= rd_rec;
    end
  end

  // key compare
  assign rd_sum  = res_pkg::score_sum(rd_rec);
  assign cur_sum = res_pkg::score_sum(cur);
  assign status.greater = cmd.by_name ? (cur.name > rd_rec.name) : (cur_sum > rd_sum);

  // sum split into quotient and remainder by three
  assign recip_prod = PROD_W'(rd_sum) * PROD_W'(res_pkg::RECIP_THIRD);
  assign q          = recip_prod[res_pkg::RECIP_SHIFT +: res_pkg::Q_W];
  assign r_full     = rd_sum - (SUM_W'(q) + (SUM_W'(q) << 1));

  always_ff @(posedge clk) begin
    if (cmd.calc_load) begin
      calc_rec <= rd_rec;
      calc_q   <= q;
      calc_r   <= r_full[1:0];
    end
  end

  assign avg = AVG_W'(calc_q) * res_pkg::TEN_THOUSAND
             + AVG_W'(res_pkg::third_frac_e4(calc_r));

  // output register
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data    <= {2'b00, avg, calc_rec.score_c, calc_rec.score_b,
                      calc_rec.score_a, calc_rec.name};
      out_last    <= cmd.out_last;
      out_dropped <= cmd.out_dropped;
    end
  end

  assign m_tdata    = out_data;
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_dropped;

endmodule

`default_nettype wire

// ----- sv/res_controller.sv -----
`default_nettype none

module res_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_wr_data,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic                 s_tlast,
  output res_pkg::res_cmd_t         cmd,
  input  wire res_pkg::res_status_t status
);

  localparam int IW = res_pkg::IDX_W;
  localparam int CW = res_pkg::CNT_W;

  typedef enum logic [8:0] {
    ST_LOAD      = 9'b000000001,
    ST_SORT_RK   = 9'b000000010,
    ST_SORT_CK   = 9'b000000100,
    ST_SORT_RH   = 9'b000001000,
    ST_SORT_CMP  = 9'b000010000,
    ST_SORT_WK   = 9'b000100000,
    ST_EMIT_RD   = 9'b001000000,
    ST_EMIT_CALC = 9'b010000000,
    ST_EMIT_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic overflow, overflow_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] h, h_next;
  logic [IW-1:0] i, i_next;
  logic [1:0] sort_key;

  logic room;
  logic [CW-1:0] count_after;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] last_k;
  logic sorting;

  // sort key register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= res_pkg::KEY_AVG;
    end else if (cfg_wr_en) begin
      sort_key <= cfg_wr_data;
    end
  end

  assign room        = count < CW'(res_pkg::MAX_RECORDS);
  assign count_after = room ? count + CW'(1) : count;
  assign last_idx    = IW'(count - CW'(1));
  assign last_k      = IW'(count - CW'(2));
  assign sorting     = (sort_key == res_pkg::KEY_AVG) || (sort_key == res_pkg::KEY_NAME);
  assign s_tready    = (state == ST_LOAD);

  // sequencer: load, exchange sort, emit
  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    k_next        = k;
    h_next        = h;
    i_next        = i;
    cmd           = '0;
    cmd.wr_src    = res_pkg::WSRC_INPUT;
    cmd.by_name   = (sort_key == res_pkg::KEY_NAME);
    case (state)
      ST_LOAD: begin
        cmd.wr_addr = IW'(count);
        if (s_tvalid) begin
          if (room) begin
            cmd.wr_en  = 1'b1;
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (s_tlast) begin
            k_next = '0;
            i_next = '0;
            if (sorting && count_after > CW'(1)) begin
              state_next = ST_SORT_RK;
            end else begin
              state_next = ST_EMIT_RD;
            end
          end
        end
      end
      ST_SORT_RK: begin
        cmd.rd_addr = k;
        state_next  = ST_SORT_CK;
      end
      ST_SORT_CK: begin
        cmd.rd_addr  = k;
        cmd.cur_load = 1'b1;
        h_next       = k + IW'(1);
        state_next   = ST_SORT_RH;
      end
      ST_SORT_RH: begin
        cmd.rd_addr = h;
        state_next  = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // swap when greater: candidate goes to h, entry h becomes the candidate
        cmd.rd_addr  = h;
        cmd.wr_src   = res_pkg::WSRC_CUR;
        cmd.wr_addr  = h;
        cmd.wr_en    = status.greater;
        cmd.cur_load = status.greater;
        if (h == last_idx) begin
          state_next = ST_SORT_WK;
        end else begin
          h_next     = h + IW'(1);
          state_next = ST_SORT_RH;
        end
      end
      ST_SORT_WK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = res_pkg::WSRC_CUR;
        cmd.wr_addr = k;
        if (k == last_k) begin
          i_next     = '0;
          state_next = ST_EMIT_RD;
        end else begin
          k_next     = k + IW'(1);
          state_next = ST_SORT_RK;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_addr = i;
        state_next  = ST_EMIT_CALC;
      end
      ST_EMIT_CALC: begin
        cmd.rd_addr   = i;
        cmd.calc_load = 1'b1;
        state_next    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cmd.rd_addr     = i;
        cmd.out_last    = (i == last_idx);
        cmd.out_dropped = overflow;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (i == last_idx) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = ST_LOAD;
          end else begin
            i_next     = i + IW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    h <= h_next;
    i <= i_next;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(res_pkg::MAX_RECORDS))
    else $error("record count beyond capacity");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD || state == ST_EMIT_CALC || state == ST_EMIT_OUT) |-> !cmd.wr_en)
    else $error("store written during emission");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten while full");

  a_final_leaves_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state != ST_LOAD))
    else $error("final record did not close the set");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

endmodule

`default_nettype wire

// ----- sv/record_exchange_sorter.sv -----
`default_nettype none

// Record exchange sorter. Records arrive one per transfer and are stored at one per
// cycle, up to 32; extra records are discarded and the set's results carry the dropped
// flag. The transfer with tlast closes the set: for sort key 1 (score sum) or 2 (packed
// name) the stored n records are exchange-sorted in place by one shared compare unit
// on a record store with one read and one write port; keys 0 and 3 skip this. Then every
// record is emitted with its average in ten-thousandths, rounded to nearest, after a
// store read, a divide by three and a scaling step, the last one with tlast; a record
// is not read until the one before it is in the output register. No input is taken
// from the closing transfer until the last result is in the output register. Write
// sort_key only while the block is idle.
module record_exchange_sorter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_wr_data,   // sort_key
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,       // name_chars, score_a, score_b, score_c
  input  wire logic         s_tlast,       // final_record
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata,       // out_name, out_score_a/b/c, average_e4
  output logic [0:0]        m_tuser,       // dropped
  output logic              m_tlast        // end_of_set
);

  res_pkg::res_cmd_t    cmd;
  res_pkg::res_status_t status;

  res_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tlast     (s_tlast),
    .cmd         (cmd),
    .status      (status)
  );

  res_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
